@@ hdl/fbpa_pkg.sv @@
// shared types, constants and codes of the fixed block pool allocator
package fbpa_pkg;

   // default pool capacity in blocks
   localparam int MAX_BLOCKS_DEF = 256;

   // pool layout constants
   localparam int ALIGN_BYTES   = 4;
   localparam int HEADER_BYTES  = 8;
   localparam int CONTROL_BYTES = 28;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int PAYLOAD_W = 24;
   localparam int COUNT_W   = 9;
   // payload plus header plus rounding slack
   localparam int BSIZE_W   = PAYLOAD_W + 1;

   // configuration register indexes
   localparam logic [1:0] CSR_POOL_BASE     = 2'd0;
   localparam logic [1:0] CSR_POOL_BYTES    = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_BYTES = 2'd2;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_BADARG   = 3'd2,
      STAT_NOINIT   = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    pool_base;
      logic [ADDR_W-1:0]    pool_bytes;
      logic [PAYLOAD_W-1:0] payload_bytes;
   } cfg_type;

   typedef struct packed {
      status_type           status;
      logic [ADDR_W-1:0]    alloc_addr;
      logic [ADDR_W-1:0]    block_bytes;
      logic [COUNT_W-1:0]   block_count;
      logic [COUNT_W-1:0]   used_count;
   } rsp_type;

endpackage

@@ hdl/fbpa_ring.sv @@
// free ring storage: one write port, one registered read port
module fbpa_ring #(
   parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [fbpa_pkg::ADDR_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [fbpa_pkg::ADDR_W-1:0]   rd_data
);

   logic [fbpa_pkg::ADDR_W-1:0] mem [DEPTH];
   logic [fbpa_pkg::ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbpa_ctrl.sv @@
// command sequencer: ring pointers, counters and the init fill walk
module fbpa_ctrl #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]      req_block_addr,
   input  fbpa_pkg::cfg_type                cfg,
   input  logic                             out_free,
   output logic                             res_load,
   output fbpa_pkg::rsp_type                res,
   output logic                             ring_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]    ring_wr_addr,
   output logic [fbpa_pkg::ADDR_W-1:0]      ring_wr_data,
   output logic                             ring_rd_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]    ring_rd_addr,
   input  logic [fbpa_pkg::ADDR_W-1:0]      ring_rd_data
);

   localparam int IW  = $clog2(MAX_BLOCKS);
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int OW  = (CW > fbpa_pkg::COUNT_W) ? CW : fbpa_pkg::COUNT_W;
   localparam int AW  = fbpa_pkg::ADDR_W;
   localparam int BSW = fbpa_pkg::BSIZE_W;

   localparam logic [IW-1:0]  LAST_IDX   = IW'(MAX_BLOCKS - 1);
   localparam logic [CW-1:0]  MAX_CNT    = CW'(MAX_BLOCKS);
   localparam logic [AW-1:0]  ALIGN_MASK = AW'(fbpa_pkg::ALIGN_BYTES - 1);
   localparam logic [BSW-1:0] ROUND_MASK = BSW'(fbpa_pkg::ALIGN_BYTES - 1);
   localparam logic [AW-1:0]  CTRL_B     = AW'(fbpa_pkg::CONTROL_BYTES);
   localparam logic [AW-1:0]  FIRST_OFS  =
      AW'(fbpa_pkg::CONTROL_BYTES + fbpa_pkg::HEADER_BYTES);

   fbpa_pkg::state_type state_ff, state_in;
   fbpa_pkg::cmd_type   cmd_ff;
   logic [AW-1:0]       addr_ff;

   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [CW-1:0]  total_ff, total_in;
   logic [CW-1:0]  used_ff, used_in;
   logic [BSW-1:0] bsize_ff, bsize_in;
   logic [CW-1:0]  fill_cnt_ff, fill_cnt_in;
   logic [AW-1:0]  fill_rem_ff, fill_rem_in;
   logic [AW-1:0]  fill_addr_ff, fill_addr_in;

   logic           accept;
   logic           no_init;
   logic           alloc_ok;
   logic           free_ok;
   logic           args_bad;
   logic           fill_more;
   logic [BSW-1:0] bsize_calc;
   logic [IW-1:0]  head_next;
   logic [IW-1:0]  tail_next;

   function automatic logic [fbpa_pkg::COUNT_W-1:0] to_out(input logic [CW-1:0] v);
      logic [OW-1:0] w;
      w = OW'(v);
      return w[fbpa_pkg::COUNT_W-1:0];
   endfunction

   assign accept  = req_valid && req_ready;
   assign no_init = (total_ff == '0);
   assign alloc_ok = !no_init && (used_ff < total_ff);
   assign free_ok  = !no_init && (addr_ff != '0) && (used_ff != '0);

   assign args_bad = (cfg.pool_base == '0) || ((cfg.pool_base & ALIGN_MASK) != '0) ||
                     (cfg.pool_bytes <= CTRL_B) || (cfg.payload_bytes == '0);

   // header plus payload, rounded up to the alignment
   assign bsize_calc = (BSW'(fbpa_pkg::HEADER_BYTES) + BSW'(cfg.payload_bytes) + ROUND_MASK)
                       & ~ROUND_MASK;

   assign fill_more = (fill_rem_ff >= AW'(bsize_ff)) && (fill_cnt_ff < MAX_CNT);

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + IW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbpa_pkg::S_IDLE: begin
            if (accept) begin
               state_in = fbpa_pkg::S_EXEC;
            end
         end
         fbpa_pkg::S_EXEC: begin
            if ((cmd_ff == fbpa_pkg::CMD_INIT) && !args_bad) begin
               state_in = fbpa_pkg::S_FILL;
            end else if (out_free) begin
               state_in = fbpa_pkg::S_IDLE;
            end
         end
         fbpa_pkg::S_FILL: begin
            if (!fill_more) begin
               state_in = fbpa_pkg::S_DONE;
            end
         end
         fbpa_pkg::S_DONE: begin
            if (out_free) begin
               state_in = fbpa_pkg::S_IDLE;
            end
         end
         default: state_in = fbpa_pkg::S_IDLE;
      endcase
   end

   // outputs: handshake, ring ports and result
   always_comb begin
      req_ready       = 1'b0;
      ring_rd_en      = 1'b0;
      ring_rd_addr    = head_ff;
      ring_wr_en      = 1'b0;
      ring_wr_addr    = tail_ff;
      ring_wr_data    = addr_ff;
      res_load        = 1'b0;
      res.status      = fbpa_pkg::STAT_OK;
      res.alloc_addr  = '0;
      res.block_bytes = AW'(bsize_ff);
      res.block_count = to_out(total_ff);
      res.used_count  = to_out(used_ff);
      unique case (state_ff)
         fbpa_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            // speculative head read, used only by allocate
            ring_rd_en = accept;
         end
         fbpa_pkg::S_EXEC: begin
            res_load = out_free && !((cmd_ff == fbpa_pkg::CMD_INIT) && !args_bad);
            case (cmd_ff)
               fbpa_pkg::CMD_INIT: begin
                  res.status = fbpa_pkg::STAT_BADARG;
               end
               fbpa_pkg::CMD_ALLOC: begin
                  if (no_init) begin
                     res.status = fbpa_pkg::STAT_NOINIT;
                  end else if (!alloc_ok) begin
                     res.status = fbpa_pkg::STAT_EMPTY;
                  end else begin
                     res.alloc_addr = ring_rd_data;
                     res.used_count = to_out(used_ff + CW'(1));
                  end
               end
               fbpa_pkg::CMD_FREE: begin
                  if (no_init) begin
                     res.status = fbpa_pkg::STAT_NOINIT;
                  end else if (addr_ff == '0) begin
                     res.status = fbpa_pkg::STAT_OK;
                  end else if (!free_ok) begin
                     res.status = fbpa_pkg::STAT_OVERFLOW;
                  end else begin
                     ring_wr_en     = out_free;
                     res.used_count = to_out(used_ff - CW'(1));
                  end
               end
               default: begin
                  res.status = fbpa_pkg::STAT_OK;
               end
            endcase
         end
         fbpa_pkg::S_FILL: begin
            ring_wr_en   = fill_more;
            ring_wr_addr = fill_cnt_ff[IW-1:0];
            ring_wr_data = fill_addr_ff;
         end
         fbpa_pkg::S_DONE: begin
            res_load   = out_free;
            res.status = no_init ? fbpa_pkg::STAT_BADARG : fbpa_pkg::STAT_OK;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      bsize_in     = bsize_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_rem_in  = fill_rem_ff;
      fill_addr_in = fill_addr_ff;
      if (state_ff == fbpa_pkg::S_EXEC) begin
         case (cmd_ff)
            fbpa_pkg::CMD_INIT: begin
               if (!args_bad) begin
                  bsize_in     = bsize_calc;
                  fill_cnt_in  = '0;
                  fill_rem_in  = cfg.pool_bytes - CTRL_B;
                  fill_addr_in = cfg.pool_base + FIRST_OFS;
               end
            end
            fbpa_pkg::CMD_ALLOC: begin
               if (alloc_ok && out_free) begin
                  head_in = head_next;
                  used_in = used_ff + CW'(1);
               end
            end
            fbpa_pkg::CMD_FREE: begin
               if (free_ok && out_free) begin
                  tail_in = tail_next;
                  used_in = used_ff - CW'(1);
               end
            end
            default: begin
               used_in = used_ff;
            end
         endcase
      end else if (state_ff == fbpa_pkg::S_FILL) begin
         if (fill_more) begin
            fill_cnt_in  = fill_cnt_ff + CW'(1);
            fill_rem_in  = fill_rem_ff - AW'(bsize_ff);
            fill_addr_in = fill_addr_ff + AW'(bsize_ff);
         end else begin
            // commit the rebuilt pool
            total_in = fill_cnt_ff;
            used_in  = '0;
            head_in  = '0;
            tail_in  = (fill_cnt_ff == MAX_CNT) ? '0 : fill_cnt_ff[IW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbpa_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         total_ff <= '0;
         used_ff  <= '0;
         bsize_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         total_ff <= total_in;
         used_ff  <= used_in;
         bsize_ff <= bsize_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_cnt_ff  <= fill_cnt_in;
      fill_rem_ff  <= fill_rem_in;
      fill_addr_ff <= fill_addr_in;
      if (accept) begin
         cmd_ff  <= fbpa_pkg::cmd_type'(req_cmd);
         addr_ff <= req_block_addr;
      end
   end

endmodule

@@ hdl/fixed_block_pool_allocator_core.sv @@
// top level of the fixed block pool allocator: registers, sequencer, ring, result stage
//
// usage
//   csr channel: write pool_base (index 0), pool_bytes (index 1) and
//   payload_bytes (index 2) while the block is idle; csr_ready is always high
//   req channel: one transaction per command (init, allocate, free)
//   rsp channel: exactly one transaction per request, in request order
// sequence
//   allocate, free and no-op: the accept cycle starts a read
//   of the ring head, the next cycle decides and loads the result register
//   init steps through accept, decide, the fill walk and a final result step;
//   the fill walk builds at most MAX_BLOCKS blocks and writes one ring entry
//   per cycle through the single write port; it finds the block count by
//   repeated subtraction
//   bad init arguments answer from the decide step
// reset
//   synchronous; clears the registers, pointers and counts, so the pool
//   reads as not initialised; the ring itself is not cleared
// stall
//   a finished result waits in the output register; the next request is accepted
//   meanwhile and holds in its decide step (a good init in its result step) until the register frees
module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]         csr_wdata,
   // requests
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]         req_block_addr,
   // responses
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]         rsp_alloc_addr,
   output logic [fbpa_pkg::ADDR_W-1:0]         rsp_block_bytes,
   output logic [fbpa_pkg::COUNT_W-1:0]        rsp_block_count,
   output logic [fbpa_pkg::COUNT_W-1:0]        rsp_used_count
);

   localparam int IW = $clog2(MAX_BLOCKS);

   fbpa_pkg::cfg_type cfg_ff;
   fbpa_pkg::rsp_type res;
   fbpa_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              res_load;
   logic              out_free;

   logic                        ring_wr_en;
   logic [IW-1:0]               ring_wr_addr;
   logic [fbpa_pkg::ADDR_W-1:0] ring_wr_data;
   logic                        ring_rd_en;
   logic [IW-1:0]               ring_rd_addr;
   logic [fbpa_pkg::ADDR_W-1:0] ring_rd_data;

   // configuration registers, writes never stall
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fbpa_pkg::CSR_POOL_BASE:     cfg_ff.pool_base     <= csr_wdata;
            fbpa_pkg::CSR_POOL_BYTES:    cfg_ff.pool_bytes    <= csr_wdata;
            fbpa_pkg::CSR_PAYLOAD_BYTES: cfg_ff.payload_bytes <=
               csr_wdata[fbpa_pkg::PAYLOAD_W-1:0];
            default: cfg_ff <= cfg_ff;  // unused index, write dropped
         endcase
      end
   end

   // sequencer
   fbpa_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_block_addr (req_block_addr),
      .cfg            (cfg_ff),
      .out_free       (out_free),
      .res_load       (res_load),
      .res            (res),
      .ring_wr_en     (ring_wr_en),
      .ring_wr_addr   (ring_wr_addr),
      .ring_wr_data   (ring_wr_data),
      .ring_rd_en     (ring_rd_en),
      .ring_rd_addr   (ring_rd_addr),
      .ring_rd_data   (ring_rd_data)
   );

   // free ring memory
   fbpa_ring #(
      .DEPTH (MAX_BLOCKS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // result register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_alloc_addr  = rsp_data_ff.alloc_addr;
   assign rsp_block_bytes = rsp_data_ff.block_bytes;
   assign rsp_block_count = rsp_data_ff.block_count;
   assign rsp_used_count  = rsp_data_ff.used_count;

endmodule

@@ hdl/fbpa_checker.sv @@
// port level checks of the allocator, bound to the top level
module fbpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [fbpa_pkg::ADDR_W-1:0]   rsp_alloc_addr,
   input logic [fbpa_pkg::COUNT_W-1:0]  rsp_block_count,
   input logic [fbpa_pkg::COUNT_W-1:0]  rsp_used_count
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_alloc_addr))
      else $error("stalled response changed");

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // no address handed out on a failing command
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fbpa_pkg::STAT_OK) |-> rsp_alloc_addr == '0)
      else $error("address returned with error status");

   // never more blocks in use than exist
   a_used_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_count <= rsp_block_count)
      else $error("used count exceeds block count");

   // reset empties the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_alloc_addr  (rsp_alloc_addr),
   .rsp_block_count (rsp_block_count),
   .rsp_used_count  (rsp_used_count)
);

@@ dv/tb_fixed_block_pool_allocator_core.sv @@
// testbench of the fixed block pool allocator core: scoreboard class, drivers, checks
module tb_fixed_block_pool_allocator_core;
   import fbpa_pkg::*;

   // clock, run length and pacing
   localparam int CLK_PERIOD       = 12;
   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_ITEMS     = 1800;
   localparam int POOL_DEPTH       = MAX_BLOCKS_DEF;
   // longest init walks the whole ring, so settle a little beyond it
   localparam int SETTLE_CYCLES    = POOL_DEPTH + 40;
   localparam int DRAIN_IDLE       = 4;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int TIMEOUT_CYCLES   = 1000000;
   localparam int MAX_REPORTS      = 10;

   // index with no register behind it, writes to it must be dropped
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_RARE,
      RX_PATTERN
   } rx_mode_type;

   // ways to break the init arguments
   typedef enum logic [1:0] {
      BAD_BASE_ZERO,
      BAD_BASE_ALIGN,
      BAD_POOL_SHORT,
      BAD_PAYLOAD_ZERO
   } bad_arg_type;

   // scoreboard: tracks the pool state, predicts one response per request
   // and compares responses in order
   class pool_scoreboard;
      bit [31:0]   reg_base;
      bit [31:0]   reg_bytes;
      bit [23:0]   reg_payload;
      bit [31:0]   free_slots [POOL_DEPTH];
      int unsigned rd_slot;
      int unsigned wr_slot;
      bit [8:0]    total_blocks;
      bit [8:0]    blocks_out;
      bit [31:0]   span_bytes;
      rsp_type     expected_rsp [$];
      int          mismatches;
      int          checked;
      int          status_hits [5];

      function void write_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_POOL_BASE:     reg_base = data;
            CSR_POOL_BYTES:    reg_bytes = data;
            CSR_PAYLOAD_BYTES: reg_payload = data[23:0];
            default: ;
         endcase
      endfunction

      function int pending_count();
         return expected_rsp.size();
      endfunction

      // apply one accepted request to the pool and queue its response
      function rsp_type note_request(cmd_type cmd, logic [31:0] addr);
         rsp_type         r;
         longint unsigned span;
         longint unsigned count;
         bit [31:0]       slot_addr;
         r.status = STAT_OK;
         r.alloc_addr = '0;
         case (cmd)
            CMD_INIT: begin
               if (reg_base == 0 || reg_base % ALIGN_BYTES != 0 ||
                   reg_bytes <= CONTROL_BYTES || reg_payload == 0) begin
                  // bad arguments leave everything as it was
                  r.status = STAT_BADARG;
               end else begin
                  span = (64'(HEADER_BYTES) + reg_payload + 64'(ALIGN_BYTES - 1)) /
                         ALIGN_BYTES * ALIGN_BYTES;
                  span_bytes = span[31:0];
                  count = reg_bytes - 32'(CONTROL_BYTES);
                  count = count / span;
                  total_blocks = (count > POOL_DEPTH) ? 9'(POOL_DEPTH) : 9'(count);
                  blocks_out = '0;
                  rd_slot = 0;
                  wr_slot = 0;
                  // no room for a single block: pool drops back to not initialised
                  if (total_blocks == 0)
                     r.status = STAT_BADARG;
                  slot_addr = reg_base + 32'(CONTROL_BYTES + HEADER_BYTES);
                  for (int k = 0; k < total_blocks; k++) begin
                     free_slots[wr_slot] = slot_addr;
                     wr_slot = (wr_slot + 1) % POOL_DEPTH;
                     slot_addr += span_bytes;
                  end
               end
            end
            CMD_ALLOC: begin
               if (total_blocks == 0) begin
                  r.status = STAT_NOINIT;
               end else if (blocks_out >= total_blocks) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.alloc_addr = free_slots[rd_slot];
                  rd_slot = (rd_slot + 1) % POOL_DEPTH;
                  blocks_out++;
               end
            end
            CMD_FREE: begin
               if (total_blocks == 0) begin
                  r.status = STAT_NOINIT;
               end else if (addr == 0) begin
                  r.status = STAT_OK;
               end else if (blocks_out == 0) begin
                  r.status = STAT_OVERFLOW;
               end else begin
                  // any address is queued, foreign or not
                  free_slots[wr_slot] = addr;
                  wr_slot = (wr_slot + 1) % POOL_DEPTH;
                  blocks_out--;
               end
            end
            default: ;
         endcase
         r.block_bytes = span_bytes;
         r.block_count = total_blocks;
         r.used_count = blocks_out;
         expected_rsp.push_back(r);
         return r;
      endfunction

      function void check_response(logic [2:0] st, logic [31:0] aa, logic [31:0] bb,
                                   logic [8:0] bc, logic [8:0] uc);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] response with nothing pending: status %0d addr %h size %h",
                        $time, st, aa, bb, " count %0d used %0d", bc, uc);
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         status_hits[want.status]++;
         if (want.status !== st || want.alloc_addr !== aa || want.block_bytes !== bb ||
             want.block_count !== bc || want.used_count !== uc) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] response %0d expected status %0d addr %h size %h count %0d used %0d",
                        $time, checked, want.status, want.alloc_addr, want.block_bytes,
                        want.block_count, want.used_count);
               $display("[%0t] response %0d actual   status %0d addr %h size %h count %0d used %0d",
                        $time, checked, st, aa, bb, bc, uc);
            end
         end
      endfunction
   endclass

   // every input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_POOL_BASE;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cmd_type     req_cmd = CMD_NOP;
   logic [31:0] req_block_addr = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_alloc_addr;
   logic [31:0] rsp_block_bytes;
   logic [8:0]  rsp_block_count;
   logic [8:0]  rsp_used_count;

   pool_scoreboard sb;

   // stimulus bookkeeping
   logic [31:0] held_addrs [$];     // addresses handed out and not yet returned
   int          requests_sent;
   int          random_items;
   int          settings_loaded;
   int          burst_left;
   bit          gap_enable;

   // receiver control, shared between the stimulus and the receiver process
   rx_mode_type rsp_stall_mode = RX_COIN;
   bit          hold_request;
   int          hold_left;
   int          hold_count;
   int          stall_tick;

   fixed_block_pool_allocator_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_alloc_addr  (rsp_alloc_addr),
      .rsp_block_bytes (rsp_block_bytes),
      .rsp_block_count (rsp_block_count),
      .rsp_used_count  (rsp_used_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver: a long hold-off when asked for, otherwise the current stall style
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         hold_count++;
      end
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_stall_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_RARE:   rsp_ready <= ($urandom_range(0, 5) != 0);
            default:   rsp_ready <= ((stall_tick % 7) < 4);
         endcase
      end
   end

   // response monitor: values read right after the edge are the ones the edge sampled
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_alloc_addr, rsp_block_bytes, rsp_block_count,
                           rsp_used_count);
   end

   // one register write; csr_valid is left high so back-to-back writes need one assignment
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // one request transaction; req_valid stays high, the caller lowers it on a gap
   task automatic send_request(input cmd_type cmd, input logic [31:0] addr);
      rsp_type predicted;
      req_cmd <= cmd;
      req_block_addr <= addr;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = sb.note_request(cmd, addr);
      requests_sent++;
      // keep the list of live blocks in step with the pool
      if (cmd == CMD_ALLOC && predicted.status == STAT_OK)
         held_addrs.push_back(predicted.alloc_addr);
      else if (cmd == CMD_INIT && (predicted.status == STAT_OK || predicted.block_count == 0))
         held_addrs.delete();
   endtask

   // sender with bursts of random length and, when enabled, random gaps between them
   task automatic offer_request(input cmd_type cmd, input logic [31:0] addr);
      int gap;
      if (gap_enable && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      send_request(cmd, addr);
   endtask

   // stop offering and wait until every pending response is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_IDLE) @(posedge clock);
   endtask

   // load all three registers, rotated from a random first one, while the block is idle
   task automatic load_config(input logic [31:0] base, input logic [31:0] bytes,
                              input logic [31:0] payload_word);
      int         first;
      logic [1:0] idx;
      drain_pipeline();
      first = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         idx = 2'((first + i) % 3);
         case (idx)
            CSR_POOL_BASE:  write_csr(idx, base);
            CSR_POOL_BYTES: write_csr(idx, bytes);
            default:        write_csr(idx, payload_word);
         endcase
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // pick a pool setting: mostly small pools so empty and overflow show up often
   task automatic choose_pool_setting(output logic [31:0] base, output logic [31:0] bytes,
                                      output logic [31:0] payload_word);
      int unsigned pick;
      int unsigned payload;
      int unsigned span;
      int unsigned blocks;
      bad_arg_type fault;
      pick = $urandom_range(0, 99);
      base = $urandom & ~32'h3;
      if (base == 0)
         base = 32'h4;
      payload = $urandom_range(1, 40);
      blocks = $urandom_range(1, 8);
      if (pick >= 55 && pick < 65) begin
         payload = $urandom_range(1, 200);
         blocks = $urandom_range(9, 40);
      end
      span = (HEADER_BYTES + payload + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      bytes = CONTROL_BYTES + span * blocks + $urandom_range(0, span - 1);
      // upper byte of the payload word is junk the register must drop
      payload_word = {8'($urandom), 24'(payload)};
      if (pick >= 65 && pick < 73) begin
         // huge region, count saturates at full ring depth
         bytes = 32'hFFF0_0000 | $urandom;
      end else if (pick >= 73 && pick < 80) begin
         base = $urandom;
         bytes = $urandom;
         payload_word = $urandom;
      end else if (pick >= 80 && pick < 86) begin
         fault = bad_arg_type'($urandom_range(0, 3));
         case (fault)
            BAD_BASE_ZERO:  base = '0;
            BAD_BASE_ALIGN: base = base | $urandom_range(1, 3);
            BAD_POOL_SHORT: bytes = $urandom_range(0, CONTROL_BYTES);
            default:        payload_word[23:0] = '0;
         endcase
      end else if (pick >= 86 && pick < 90) begin
         // past the control area but short of one block
         bytes = CONTROL_BYTES + $urandom_range(1, span - 1);
      end else if (pick >= 90) begin
         // block addresses run past the top of the address space
         base = 32'hFFFF_FFFC - 4 * $urandom_range(0, 64);
      end
   endtask

   // one phase: init, then mostly alloc/free of live blocks with some noise
   task automatic run_random_phase(input int n_items, input bit pressure);
      int          pick;
      int          slot;
      logic [31:0] addr;
      rsp_stall_mode = pressure ? RX_ALWAYS : rx_mode_type'($urandom_range(0, 3));
      gap_enable = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
      burst_left = 0;
      send_request(CMD_INIT, $urandom);
      random_items++;
      // receiver goes quiet while the sender keeps pushing, so the input backs up
      if (pressure)
         hold_request = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 44) begin
            offer_request(CMD_ALLOC, $urandom);
            random_items++;
         end else if (pick < 76 && held_addrs.size() != 0) begin
            slot = $urandom_range(0, held_addrs.size() - 1);
            addr = held_addrs[slot];
            held_addrs.delete(slot);
            offer_request(CMD_FREE, addr);
            random_items++;
         end else if (pick < 84) begin
            offer_request(CMD_FREE, $urandom);
            random_items++;
         end else if (pick < 88) begin
            offer_request(CMD_FREE, 32'h0);
         end else if (pick < 94) begin
            offer_request(CMD_NOP, $urandom);
         end else begin
            offer_request(CMD_INIT, $urandom);
            random_items++;
         end
         // now and then let the pipeline run dry mid-phase
         if ($urandom_range(0, 149) == 0)
            drain_pipeline();
      end
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] bytes;
      logic [31:0] payload_word;
      int          phase_no;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // fresh from reset: registers zero, pool not initialised
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_FREE, 32'h0000_1234);
      send_request(CMD_NOP, 32'hFFFF_FFFF);
      send_request(CMD_INIT, 32'h0);
      // misaligned base
      load_config(32'h0000_1002, 32'd100, 32'd4);
      send_request(CMD_INIT, 32'h0);
      // region no larger than the control area
      load_config(32'h0000_1000, 32'(CONTROL_BYTES), 32'd4);
      send_request(CMD_INIT, 32'h0);
      // payload zero once the upper byte is dropped
      load_config(32'h0000_1000, 32'd1000, 32'hFF00_0000);
      send_request(CMD_INIT, 32'h0);
      // too small for one block: size is updated, pool stays not initialised
      load_config(32'h0000_1000, 32'(CONTROL_BYTES + 1), 32'd1);
      send_request(CMD_INIT, 32'h0);
      send_request(CMD_ALLOC, 32'h0);
      // two 12-byte blocks from a base just below the top; their addresses wrap past it
      load_config(32'hFFFF_FFF0, 32'(CONTROL_BYTES + 2 * 12 + 5), 32'd1);
      send_request(CMD_INIT, 32'h0);
      send_request(CMD_FREE, 32'h0000_0055);     // overflow, nothing out yet
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_ALLOC, 32'h0);            // pool empty
      send_request(CMD_FREE, 32'h0);             // ignored
      send_request(CMD_FREE, 32'hDEAD_BEEF);     // foreign address, queued as is
      send_request(CMD_FREE, 32'h0000_0014);
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_INIT, 32'h0);             // re-init rebuilds the ring
      send_request(CMD_NOP, 32'h0);
      // largest payload, all-ones region at the top of memory
      load_config(32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_INIT, 32'h0);
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_FREE, 32'hFFFF_FFFF);
      // write to the unmapped index must change nothing
      drain_pipeline();
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      // full ring depth
      load_config(32'h0000_0004, 32'hFFFF_FFFF, 32'd1);
      send_request(CMD_INIT, 32'h0);
      send_request(CMD_ALLOC, 32'h0);
      send_request(CMD_ALLOC, 32'h0);

      // random phases, each starting from a quiet block and a new setting
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         choose_pool_setting(base, bytes, payload_word);
         load_config(base, bytes, payload_word);
         run_random_phase($urandom_range(15, 70), (phase_no % 12) == 2);
         phase_no++;
      end

      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d requests, %0d in random phases, %0d pool settings, %0d long hold-offs",
               requests_sent, random_items, settings_loaded, hold_count);
      $display("responses %0d: ok %0d, empty %0d, bad init %0d, not initialised %0d, overflow %0d",
               sb.checked, sb.status_hits[STAT_OK], sb.status_hits[STAT_EMPTY],
               sb.status_hits[STAT_BADARG], sb.status_hits[STAT_NOINIT],
               sb.status_hits[STAT_OVERFLOW]);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
